// ----- rtl/sortable_lifo_stack_core_defines.svh -----
// Assertion macros for the sortable LIFO stack core.
// Used by the checker module; expects clk and rst_n in the enclosing scope.
`ifndef SORTABLE_LIFO_STACK_CORE_DEFINES_SVH
`define SORTABLE_LIFO_STACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SLSTK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SLSTK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/slstk_pkg.sv -----
// Shared types and constants for the sortable LIFO stack core.
// No dependencies; used by the controller, datapath, top level and checker.
package slstk_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEPTH_OUT_W = 7;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (2 * DATA_W + DEPTH_OUT_W + 2);

  // Default number of stack entries.
  localparam int unsigned STACK_DEPTH_DEF = 64;

  // Operation codes carried on in_tuser.
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_SORT  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;
  typedef enum logic [1:0] {WR_NONE, WR_PUSH, WR_LOWER, WR_UPPER} wr_sel_t;
  typedef enum logic [2:0] {
    RD_SECOND, RD_TOP, RD_LOWER, RD_LOWER_M1, RD_UPPER_M1
  } rd_sel_t;
  typedef enum logic [1:0] {TOP_HOLD, TOP_PUSH, TOP_RDATA, TOP_WB} top_op_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_START, IDX_LOWER_DEC, IDX_UPPER_DEC} idx_op_t;
  typedef enum logic [1:0] {UP_HOLD, UP_LOAD, UP_CMP} up_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    cnt_op_t cnt_op;
    wr_sel_t wr_sel;
    rd_sel_t rd_sel;
    top_op_t top_op;
    idx_op_t idx_op;
    up_op_t  up_op;
    logic    res_load;
    logic    res_popped;
    logic    res_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic lt2;
    logic lower_zero;
    logic upper_one;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/sortable_lifo_stack_core.sv -----
// Sortable LIFO stack core. Push, clear, a failed push or pop, and a sort of
// fewer than two entries give their result in the cycle after the transfer,
// one item per cycle while out_tready is high. A pop first captures the new
// top from the registered read of the entry RAM in ST_POP. A sort runs one
// compare per cycle in ST_SRT_CMP through the RAM read port. Reset (rst_n low,
// synchronous) empties the stack; the entry RAM needs no clearing pass.
module sortable_lifo_stack_core #(
  parameter int unsigned STACK_DEPTH = slstk_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [slstk_pkg::DATA_W-1:0]       in_tdata,   // [31:0] push_value
  input  logic [slstk_pkg::KIND_W-1:0]       in_tuser,   // [1:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] popped_value, [63:32] top_value, [70:64] depth_count,
  // [71] empty_res, [72] error, [79:73] zero
  output logic [slstk_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  slstk_pkg::cmd_t cmd;
  slstk_pkg::sts_t sts;

  slstk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  slstk_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .push_value (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/slstk_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module slstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/slstk_ctrl.sv -----
// Controller for the sortable LIFO stack: operation decode and sort sequencer.
// Depends on slstk_pkg; drives the datapath through cmd_t and reads sts_t.
module slstk_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [slstk_pkg::KIND_W-1:0]    in_kind,
  input  slstk_pkg::sts_t                 sts,
  output slstk_pkg::cmd_t                 cmd
);

  typedef enum logic [2:0] {ST_IDLE, ST_POP, ST_SRT_LO, ST_SRT_CMP, ST_SRT_WB, ST_DONE} state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // Input is taken only when idle and the result slot is free.
  assign in_tready = (state_r == ST_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  // Command decode and next state.
  always_comb begin
    cmd            = '0;
    cmd.cnt_op     = slstk_pkg::CNT_HOLD;
    cmd.wr_sel     = slstk_pkg::WR_NONE;
    cmd.rd_sel     = slstk_pkg::RD_SECOND;
    cmd.top_op     = slstk_pkg::TOP_HOLD;
    cmd.idx_op     = slstk_pkg::IDX_HOLD;
    cmd.up_op      = slstk_pkg::UP_HOLD;
    state_nxt      = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (slstk_pkg::kind_t'(in_kind))
            slstk_pkg::KIND_PUSH: begin
              cmd.res_load = 1'b1;
              if (sts.full) begin
                cmd.res_err = 1'b1;
              end else begin
                cmd.cnt_op = slstk_pkg::CNT_INC;
                cmd.wr_sel = slstk_pkg::WR_PUSH;
                cmd.top_op = slstk_pkg::TOP_PUSH;
              end
            end
            slstk_pkg::KIND_POP: begin
              if (sts.empty) begin
                cmd.res_load = 1'b1;
                cmd.res_err  = 1'b1;
              end else begin
                // Fetch the entry that becomes the new top.
                cmd.cnt_op = slstk_pkg::CNT_DEC;
                cmd.rd_sel = slstk_pkg::RD_SECOND;
                state_nxt  = ST_POP;
              end
            end
            slstk_pkg::KIND_SORT: begin
              if (sts.lt2) begin
                cmd.res_load = 1'b1;
              end else begin
                cmd.rd_sel = slstk_pkg::RD_TOP;
                cmd.idx_op = slstk_pkg::IDX_START;
                state_nxt  = ST_SRT_LO;
              end
            end
            default: begin
              cmd.cnt_op   = slstk_pkg::CNT_CLR;
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd.top_op     = slstk_pkg::TOP_RDATA;
        cmd.res_load   = 1'b1;
        cmd.res_popped = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SRT_LO: begin
        // Capture the upper entry and start reading the first lower one.
        cmd.up_op  = slstk_pkg::UP_LOAD;
        cmd.rd_sel = slstk_pkg::RD_LOWER;
        state_nxt  = ST_SRT_CMP;
      end
      ST_SRT_CMP: begin
        cmd.up_op  = slstk_pkg::UP_CMP;
        cmd.wr_sel = slstk_pkg::WR_LOWER;
        cmd.rd_sel = slstk_pkg::RD_LOWER_M1;
        cmd.idx_op = slstk_pkg::IDX_LOWER_DEC;
        if (sts.lower_zero) begin
          state_nxt = ST_SRT_WB;
        end
      end
      ST_SRT_WB: begin
        // Store the settled upper entry and fetch the next one.
        cmd.wr_sel = slstk_pkg::WR_UPPER;
        cmd.top_op = slstk_pkg::TOP_WB;
        cmd.rd_sel = slstk_pkg::RD_UPPER_M1;
        cmd.idx_op = slstk_pkg::IDX_UPPER_DEC;
        state_nxt  = sts.upper_one ? ST_DONE : ST_SRT_LO;
      end
      ST_DONE: begin
        cmd.res_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/slstk_dpath.sv -----
// Datapath for the sortable LIFO stack: entry RAM, count, cached top, sort
// registers and the result register. Depends on slstk_pkg and slstk_ram.
module slstk_dpath #(
  parameter int unsigned STACK_DEPTH = slstk_pkg::STACK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  slstk_pkg::cmd_t                      cmd,
  output slstk_pkg::sts_t                      sts,
  input  logic [slstk_pkg::DATA_W-1:0]         push_value,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [slstk_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = slstk_pkg::DATA_W;

  logic [CW-1:0]        count_r, count_nxt;
  logic signed [DW-1:0] top_r, top_nxt;
  logic signed [DW-1:0] up_r, up_nxt;
  logic [AW-1:0]        upper_r, upper_nxt;
  logic [AW-1:0]        lower_r, lower_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;
  logic [AW-1:0]        rd_addr;
  logic signed [DW-1:0] rd_data;
  logic                 upper_gt;

  logic                 out_valid_r;
  logic [DW-1:0]        popped_r;
  logic [DW-1:0]        top_out_r;
  logic [slstk_pkg::DEPTH_OUT_W-1:0] depth_r;
  logic                 empty_r;
  logic                 err_r;

  slstk_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Signed compare of the held upper entry against the lower one being read.
  assign upper_gt = up_r > rd_data;

  // Entry count.
  always_comb begin
    case (cmd.cnt_op)
      slstk_pkg::CNT_INC: count_nxt = count_r + CW'(1);
      slstk_pkg::CNT_DEC: count_nxt = count_r - CW'(1);
      slstk_pkg::CNT_CLR: count_nxt = '0;
      default:            count_nxt = count_r;
    endcase
  end

  // Cached top entry.
  always_comb begin
    case (cmd.top_op)
      slstk_pkg::TOP_PUSH:  top_nxt = push_value;
      slstk_pkg::TOP_RDATA: top_nxt = rd_data;
      slstk_pkg::TOP_WB:    top_nxt = (upper_r == AW'(count_r - CW'(1))) ? up_r : top_r;
      default:              top_nxt = top_r;
    endcase
  end

  // RAM write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lower_r;
    wr_data = up_r;
    case (cmd.wr_sel)
      slstk_pkg::WR_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = AW'(count_r);
        wr_data = push_value;
      end
      slstk_pkg::WR_LOWER: begin
        wr_en   = upper_gt;
        wr_addr = lower_r;
      end
      slstk_pkg::WR_UPPER: begin
        wr_en   = 1'b1;
        wr_addr = upper_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // RAM read address.
  always_comb begin
    case (cmd.rd_sel)
      slstk_pkg::RD_SECOND:   rd_addr = AW'(count_r - CW'(2));
      slstk_pkg::RD_TOP:      rd_addr = AW'(count_r - CW'(1));
      slstk_pkg::RD_LOWER:    rd_addr = lower_r;
      slstk_pkg::RD_LOWER_M1: rd_addr = lower_r - AW'(1);
      slstk_pkg::RD_UPPER_M1: rd_addr = upper_r - AW'(1);
      default:                rd_addr = lower_r;
    endcase
  end

  // Held upper entry: swaps with the lower entry when it is the greater.
  always_comb begin
    case (cmd.up_op)
      slstk_pkg::UP_LOAD: up_nxt = rd_data;
      slstk_pkg::UP_CMP:  up_nxt = upper_gt ? rd_data : up_r;
      default:            up_nxt = up_r;
    endcase
  end

  // Sort indexes.
  always_comb begin
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    case (cmd.idx_op)
      slstk_pkg::IDX_START: begin
        upper_nxt = AW'(count_r - CW'(1));
        lower_nxt = AW'(count_r - CW'(2));
      end
      slstk_pkg::IDX_LOWER_DEC: begin
        lower_nxt = lower_r - AW'(1);
      end
      slstk_pkg::IDX_UPPER_DEC: begin
        upper_nxt = upper_r - AW'(1);
        lower_nxt = upper_r - AW'(2);
      end
      default: begin
        upper_nxt = upper_r;
      end
    endcase
  end

  // Status to the controller.
  always_comb begin
    sts.full       = count_r == CW'(STACK_DEPTH);
    sts.empty      = count_r == '0;
    sts.lt2        = count_r < CW'(2);
    sts.lower_zero = lower_r == '0;
    sts.upper_one  = upper_r == AW'(1);
    sts.out_free   = !out_valid_r || out_tready;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r   <= top_nxt;
    up_r    <= up_nxt;
    upper_r <= upper_nxt;
    lower_r <= lower_nxt;
    if (cmd.res_load) begin
      popped_r  <= cmd.res_popped ? top_r : '0;
      top_out_r <= (count_nxt != '0) ? top_nxt : '0;
      depth_r   <= slstk_pkg::DEPTH_OUT_W'(count_nxt);
      empty_r   <= count_nxt == '0;
      err_r     <= cmd.res_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{slstk_pkg::OUT_PAD_W{1'b0}}, err_r, empty_r, depth_r,
                       top_out_r, popped_r};

endmodule

// ----- rtl/slstk_checker.sv -----
// Port-level checks for the sortable LIFO stack core, bound to the top level.
// Depends on slstk_pkg and sortable_lifo_stack_core_defines.svh.
`include "sortable_lifo_stack_core_defines.svh"

module slstk_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [slstk_pkg::KIND_W-1:0]       in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [slstk_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result holds its value.
  `SLSTK_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // No input transfer while a result is waiting and not taken.
  `SLSTK_ASSERT_IMP(a_no_overrun, out_tvalid && !out_tready, !in_tready, "input taken while result slot is full")

  // Push and clear give their result in the next cycle.
  `SLSTK_ASSERT_NXT(a_fast_result, in_tvalid && in_tready && (in_tuser == slstk_pkg::KIND_PUSH || in_tuser == slstk_pkg::KIND_CLEAR), out_tvalid, "push or clear result late")

  // An empty stack reports zero depth and a zero top.
  `SLSTK_ASSERT_IMP(a_empty_fields, out_tvalid && out_tdata[71], out_tdata[70:64] == 7'd0 && out_tdata[63:32] == 32'd0, "empty result with nonzero depth or top")

endmodule

bind sortable_lifo_stack_core slstk_checker u_slstk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
